>>> hdl/pocx_pkg.sv
package pocx_pkg;

  localparam int CITY_W     = 5;
  localparam int CITY_SLOTS = 32;
  localparam int CUT_W      = 5;

  // Two store banks: one tour can load while the other is crossed and emitted.
  localparam int BANKS      = 2;
  localparam int BUSY_W     = $clog2(BANKS + 1);

  localparam int OUT_DEPTH  = 4;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [CITY_W-1:0] city_a;
    logic [CITY_W-1:0] city_b;
    logic [CUT_W-1:0]  cut_point;
    logic              cross_enable;
    logic              last_position;
  } in_t;

  typedef struct packed {
    logic [CITY_W-1:0] child_a;
    logic [CITY_W-1:0] child_b;
    logic              last_out;
  } out_t;

  typedef struct packed {
    logic              we;
    logic              bank;
    logic [CITY_W-1:0] city_a;
    logic [CITY_W-1:0] city_b;
  } store_wr_t;

  typedef struct packed {
    logic              bank;
    logic              cross_enable;
    logic [CUT_W-1:0]  cut_point;
  } job_hdr_t;

  typedef struct packed {
    logic [CITY_W-1:0] a0;
    logic [CITY_W-1:0] b0;
    logic [CITY_W-1:0] a1;
    logic [CITY_W-1:0] b1;
  } store_rd_t;

endpackage

>>> hdl/pocx_fifo.sv
module pocx_fifo #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 2,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/pocx_store.sv
module pocx_store #(
  parameter int  NUM_CITIES = 32,
  localparam int PW         = $clog2(NUM_CITIES)
) (
  input  logic                                clk_i,
  input  pocx_pkg::store_wr_t                 wr_i,
  input  logic [PW-1:0]                       wr_pos_i,
  input  logic                                rd_bank_i,
  input  logic [PW-1:0]                       rd_addr0_i,
  input  logic [pocx_pkg::CITY_W-1:0]         rd_pos_city_a_i,
  input  logic [pocx_pkg::CITY_W-1:0]         rd_pos_city_b_i,
  input  logic [PW-1:0]                       rd_addr1_a_i,
  input  logic [PW-1:0]                       rd_addr1_b_i,
  output pocx_pkg::store_rd_t                 rd_cities_o,
  output logic [PW-1:0]                       rd_pos_a_o,
  output logic [PW-1:0]                       rd_pos_b_o
);

  // Cities by position and position by city, one copy per bank.
  logic [pocx_pkg::CITY_W-1:0] tour_a [pocx_pkg::BANKS][NUM_CITIES];
  logic [pocx_pkg::CITY_W-1:0] tour_b [pocx_pkg::BANKS][NUM_CITIES];
  logic [PW-1:0]               pos_a  [pocx_pkg::BANKS][pocx_pkg::CITY_SLOTS];
  logic [PW-1:0]               pos_b  [pocx_pkg::BANKS][pocx_pkg::CITY_SLOTS];

  pocx_pkg::store_rd_t rd_cities_q;
  logic [PW-1:0]       rd_pos_a_q;
  logic [PW-1:0]       rd_pos_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      tour_a[wr_i.bank][wr_pos_i]    <= wr_i.city_a;
      tour_b[wr_i.bank][wr_pos_i]    <= wr_i.city_b;
      pos_a[wr_i.bank][wr_i.city_a]  <= wr_pos_i;
      pos_b[wr_i.bank][wr_i.city_b]  <= wr_pos_i;
    end
    rd_cities_q.a0 <= tour_a[rd_bank_i][rd_addr0_i];
    rd_cities_q.b0 <= tour_b[rd_bank_i][rd_addr0_i];
    rd_cities_q.a1 <= tour_a[rd_bank_i][rd_addr1_a_i];
    rd_cities_q.b1 <= tour_b[rd_bank_i][rd_addr1_b_i];
    rd_pos_a_q     <= pos_a[rd_bank_i][rd_pos_city_a_i];
    rd_pos_b_q     <= pos_b[rd_bank_i][rd_pos_city_b_i];
  end

  assign rd_cities_o = rd_cities_q;
  assign rd_pos_a_o  = rd_pos_a_q;
  assign rd_pos_b_o  = rd_pos_b_q;

endmodule

>>> hdl/pocx_front.sv
module pocx_front #(
  parameter int  NUM_CITIES = 32,
  localparam int PW         = $clog2(NUM_CITIES),
  localparam int LW         = $clog2(NUM_CITIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pocx_pkg::in_t        item_i,
  output logic                 full_o,
  output pocx_pkg::store_wr_t  wr_o,
  output logic [PW-1:0]        wr_pos_o,
  output logic                 job_push_o,
  output pocx_pkg::job_hdr_t   job_hdr_o,
  output logic [LW-1:0]        job_len_o,
  input  logic                 release_i
);

  logic [LW-1:0]               cnt_q, cnt_d;
  logic                        bank_q, bank_d;
  logic [pocx_pkg::BUSY_W-1:0] busy_q, busy_d;
  logic                        accept;
  logic                        room;
  logic [LW-1:0]               len_next;

  // A bank stays owned from the end of its load until the back end has read it out.
  assign full_o   = (busy_q == pocx_pkg::BUSY_W'(pocx_pkg::BANKS));
  assign accept   = push_i && !full_o;
  assign room     = (cnt_q < LW'(NUM_CITIES));
  assign len_next = room ? cnt_q + LW'(1) : cnt_q;

  assign wr_o.we     = accept && room;
  assign wr_o.bank   = bank_q;
  assign wr_o.city_a = item_i.city_a;
  assign wr_o.city_b = item_i.city_b;
  assign wr_pos_o    = cnt_q[PW-1:0];

  assign job_push_o             = accept && item_i.last_position;
  assign job_hdr_o.bank         = bank_q;
  assign job_hdr_o.cross_enable = item_i.cross_enable;
  assign job_hdr_o.cut_point    = item_i.cut_point;
  assign job_len_o              = len_next;

  always_comb begin
    cnt_d  = cnt_q;
    bank_d = bank_q;
    if (accept) begin
      if (item_i.last_position) begin
        cnt_d  = '0;
        bank_d = !bank_q;
      end else begin
        cnt_d  = len_next;
      end
    end
    unique case ({job_push_o, release_i})
      2'b10:   busy_d = busy_q + pocx_pkg::BUSY_W'(1);
      2'b01:   busy_d = busy_q - pocx_pkg::BUSY_W'(1);
      default: busy_d = busy_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

>>> hdl/pocx_back.sv
module pocx_back #(
  parameter int  NUM_CITIES = 32,
  localparam int PW         = $clog2(NUM_CITIES),
  localparam int LW         = $clog2(NUM_CITIES + 1),
  localparam int CMPW       = (LW > pocx_pkg::CUT_W) ? LW : pocx_pkg::CUT_W
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  pocx_pkg::job_hdr_t               job_hdr_i,
  input  logic [LW-1:0]                    job_len_i,
  output logic                             job_pop_o,
  output logic                             rd_bank_o,
  output logic [PW-1:0]                    rd_addr0_o,
  output logic [pocx_pkg::CITY_W-1:0]      rd_pos_city_a_o,
  output logic [pocx_pkg::CITY_W-1:0]      rd_pos_city_b_o,
  output logic [PW-1:0]                    rd_addr1_a_o,
  output logic [PW-1:0]                    rd_addr1_b_o,
  input  pocx_pkg::store_rd_t              rd_cities_i,
  input  logic [PW-1:0]                    rd_pos_a_i,
  input  logic [PW-1:0]                    rd_pos_b_i,
  input  logic [pocx_pkg::OUT_CNT_W-1:0]   out_count_i,
  output logic                             out_push_o,
  output pocx_pkg::out_t                   out_data_o,
  output logic                             release_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic                bank_q;
  logic                en_q;
  logic [CMPW-1:0]     cut_q;
  logic [LW-1:0]       len_q;
  logic [LW-1:0]       s_q;
  logic [LW-1:0]       t_q;
  logic [LW-1:0]       ta_q;
  logic [LW-1:0]       tb_q;
  logic                v1_q, v2_q, v3_q;
  logic                e1_q;
  logic                elast_q;
  logic [LW-1:0]       epos_q;

  logic [pocx_pkg::CITY_W-1:0] ca2_q, cb2_q, ca3_q, cb3_q;
  logic [PW-1:0]               pa3_q, pb3_q;
  logic [pocx_pkg::CITY_W-1:0] ka_q, kb_q;

  // Tail cities found by the scan, at their child positions.
  logic [pocx_pkg::CITY_W-1:0] kid_a [NUM_CITIES];
  logic [pocx_pkg::CITY_W-1:0] kid_b [NUM_CITIES];

  logic                        issue_emit;
  logic [pocx_pkg::OUT_CNT_W:0] credit_used;
  logic                        hit_a, hit_b;
  logic                        sel_a, sel_b;
  logic [CMPW-1:0]             job_cut;
  logic [LW-1:0]               tail_start;

  assign credit_used = {1'b0, out_count_i} + {{pocx_pkg::OUT_CNT_W{1'b0}}, e1_q};
  assign issue_emit  = (state_q == S_EMIT) &&
                       (credit_used < (pocx_pkg::OUT_CNT_W + 1)'(pocx_pkg::OUT_DEPTH));

  assign job_pop_o  = (state_q == S_IDLE) && job_valid_i;
  assign release_o  = issue_emit && ((t_q + LW'(1)) == len_q);

  assign rd_bank_o       = bank_q;
  assign rd_addr0_o      = (state_q == S_EMIT) ? t_q[PW-1:0] : s_q[PW-1:0];
  // Child A looks up the cities of B in A's position map, and the other way round.
  assign rd_pos_city_a_o = rd_cities_i.b0;
  assign rd_pos_city_b_o = rd_cities_i.a0;
  assign rd_addr1_a_o    = rd_pos_a_i;
  assign rd_addr1_b_o    = rd_pos_b_i;

  // A scanned city is a tail city of the child's own parent only if that parent
  // really holds it at the mapped tail position.
  assign hit_a = v3_q && (CMPW'(pa3_q) >= cut_q) && (LW'(pa3_q) < len_q) &&
                 (rd_cities_i.a1 == cb3_q) && (ta_q < len_q);
  assign hit_b = v3_q && (CMPW'(pb3_q) >= cut_q) && (LW'(pb3_q) < len_q) &&
                 (rd_cities_i.b1 == ca3_q) && (tb_q < len_q);

  assign job_cut    = CMPW'(job_hdr_i.cut_point);
  assign tail_start = (job_cut < CMPW'(job_len_i)) ? job_cut[LW-1:0] : job_len_i;

  assign sel_a = en_q && (CMPW'(epos_q) >= cut_q) && (epos_q < ta_q);
  assign sel_b = en_q && (CMPW'(epos_q) >= cut_q) && (epos_q < tb_q);

  assign out_push_o          = e1_q;
  assign out_data_o.child_a  = sel_a ? ka_q : rd_cities_i.a0;
  assign out_data_o.child_b  = sel_b ? kb_q : rd_cities_i.b0;
  assign out_data_o.last_out = elast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      en_q    <= 1'b0;
      cut_q   <= CMPW'(1);
      len_q   <= '0;
      s_q     <= '0;
      t_q     <= '0;
      ta_q    <= '0;
      tb_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      e1_q    <= 1'b0;
      elast_q <= 1'b0;
      epos_q  <= '0;
    end else begin
      v1_q <= (state_q == S_SCAN);
      v2_q <= v1_q;
      v3_q <= v2_q;
      e1_q <= issue_emit;
      if (issue_emit) begin
        epos_q  <= t_q;
        elast_q <= ((t_q + LW'(1)) == len_q);
      end
      if (hit_a) begin
        ta_q <= ta_q + LW'(1);
      end
      if (hit_b) begin
        tb_q <= tb_q + LW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            bank_q  <= job_hdr_i.bank;
            en_q    <= job_hdr_i.cross_enable;
            cut_q   <= job_cut;
            len_q   <= job_len_i;
            ta_q    <= tail_start;
            tb_q    <= tail_start;
            s_q     <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          s_q <= s_q + LW'(1);
          if ((s_q + LW'(1)) == len_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q && !v3_q) begin
            t_q     <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (issue_emit) begin
            t_q <= t_q + LW'(1);
            if ((t_q + LW'(1)) == len_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ca2_q <= rd_cities_i.a0;
    cb2_q <= rd_cities_i.b0;
    ca3_q <= ca2_q;
    cb3_q <= cb2_q;
    pa3_q <= rd_pos_a_i;
    pb3_q <= rd_pos_b_i;
    if (hit_a) begin
      kid_a[ta_q[PW-1:0]] <= cb3_q;
    end
    if (hit_b) begin
      kid_b[tb_q[PW-1:0]] <= ca3_q;
    end
    ka_q <= kid_a[t_q[PW-1:0]];
    kb_q <= kid_b[t_q[PW-1:0]];
  end

endmodule

>>> hdl/permutation_order_crossover.sv
// Order-based crossover of two city tours. Each pushed word carries one position of both
// parent tours; the word flagged as last position closes the tour and supplies the cut point
// and crossover enable. Each child keeps its own parent's cities before the cut and then lists
// that parent's remaining cities in the order the other parent holds them; with the enable
// off the children equal the parents. Words past NUM_CITIES positions are dropped, but a last
// word still closes the tour. Each tour loads into one of two store banks while full is low,
// and the next tour loads into the other bank while this one is worked: a pipelined scan,
// then one child position per cycle as long as the result queue is popped. A tour occupies
// the back end from pick-up until its last child position is issued, so the back end works
// one tour at a time; full rises only when both banks hold tours not yet read out.
module permutation_order_crossover #(
  parameter int NUM_CITIES = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  pocx_pkg::in_t  item_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output pocx_pkg::out_t result_o
);

  localparam int PW     = $clog2(NUM_CITIES);
  localparam int LW     = $clog2(NUM_CITIES + 1);
  localparam int HDR_W  = $bits(pocx_pkg::job_hdr_t);
  localparam int JOB_W  = HDR_W + LW;
  localparam int OUT_W  = $bits(pocx_pkg::out_t);

  pocx_pkg::store_wr_t  st_wr;
  logic [PW-1:0]        st_wr_pos;
  logic                 job_push;
  pocx_pkg::job_hdr_t   job_wr_hdr;
  logic [LW-1:0]        job_wr_len;
  logic [JOB_W-1:0]     job_wdata;
  logic [JOB_W-1:0]     job_rdata;
  logic                 job_full;
  logic                 job_empty;
  logic                 job_pop;
  logic [pocx_pkg::BUSY_W-1:0] job_count;
  pocx_pkg::job_hdr_t   job_rd_hdr;
  logic [LW-1:0]        job_rd_len;
  logic                 bank_release;

  logic                        rd_bank;
  logic [PW-1:0]               rd_addr0;
  logic [pocx_pkg::CITY_W-1:0] rd_pos_city_a;
  logic [pocx_pkg::CITY_W-1:0] rd_pos_city_b;
  logic [PW-1:0]               rd_addr1_a;
  logic [PW-1:0]               rd_addr1_b;
  pocx_pkg::store_rd_t         rd_cities;
  logic [PW-1:0]               rd_pos_a;
  logic [PW-1:0]               rd_pos_b;

  logic                          out_push;
  pocx_pkg::out_t                out_wdata;
  logic [OUT_W-1:0]              out_rdata;
  logic                          out_full;
  logic [pocx_pkg::OUT_CNT_W-1:0] out_count;

  pocx_front #(
    .NUM_CITIES (NUM_CITIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .wr_o       (st_wr),
    .wr_pos_o   (st_wr_pos),
    .job_push_o (job_push),
    .job_hdr_o  (job_wr_hdr),
    .job_len_o  (job_wr_len),
    .release_i  (bank_release)
  );

  pocx_store #(
    .NUM_CITIES (NUM_CITIES)
  ) u_store (
    .clk_i           (clk_i),
    .wr_i            (st_wr),
    .wr_pos_i        (st_wr_pos),
    .rd_bank_i       (rd_bank),
    .rd_addr0_i      (rd_addr0),
    .rd_pos_city_a_i (rd_pos_city_a),
    .rd_pos_city_b_i (rd_pos_city_b),
    .rd_addr1_a_i    (rd_addr1_a),
    .rd_addr1_b_i    (rd_addr1_b),
    .rd_cities_o     (rd_cities),
    .rd_pos_a_o      (rd_pos_a),
    .rd_pos_b_o      (rd_pos_b)
  );

  assign job_wdata  = {job_wr_hdr, job_wr_len};
  assign job_rd_hdr = pocx_pkg::job_hdr_t'(job_rdata[JOB_W-1 -: HDR_W]);
  assign job_rd_len = job_rdata[LW-1:0];

  pocx_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (pocx_pkg::BANKS)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty),
    .count_o (job_count)
  );

  pocx_back #(
    .NUM_CITIES (NUM_CITIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (!job_empty),
    .job_hdr_i       (job_rd_hdr),
    .job_len_i       (job_rd_len),
    .job_pop_o       (job_pop),
    .rd_bank_o       (rd_bank),
    .rd_addr0_o      (rd_addr0),
    .rd_pos_city_a_o (rd_pos_city_a),
    .rd_pos_city_b_o (rd_pos_city_b),
    .rd_addr1_a_o    (rd_addr1_a),
    .rd_addr1_b_o    (rd_addr1_b),
    .rd_cities_i     (rd_cities),
    .rd_pos_a_i      (rd_pos_a),
    .rd_pos_b_i      (rd_pos_b),
    .out_count_i     (out_count),
    .out_push_o      (out_push),
    .out_data_o      (out_wdata),
    .release_o       (bank_release)
  );

  pocx_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (pocx_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign result_o = pocx_pkg::out_t'(out_rdata);

  // The bank count bounds the tours in flight, so the tour queue never overflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("tour queue written while full");

  // Emission reserves queue space before reading, so no child word is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_push |-> !out_full)
    else $error("result queue written while full");

  // With both banks owned, at least one finished tour must still wait for the back end.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> (job_count != '0))
    else $error("both banks owned but no tour queued");

endmodule
